[sv/tsg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tsg_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_IP_IDENT  = 3'd0;
  localparam logic [2:0] REG_SRC_PORT  = 3'd1;
  localparam logic [2:0] REG_DST_PORT  = 3'd2;
  localparam logic [2:0] REG_WINDOW    = 3'd3;
  localparam logic [2:0] REG_SEQ_NUM   = 3'd4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Positions of the ten header words
  localparam logic [3:0] WORD_VER_LEN   = 4'd0;
  localparam logic [3:0] WORD_IDENT     = 4'd1;
  localparam logic [3:0] WORD_TTL_CSUM  = 4'd2;
  localparam logic [3:0] WORD_SRC_ADDR  = 4'd3;
  localparam logic [3:0] WORD_DST_ADDR  = 4'd4;
  localparam logic [3:0] WORD_PORTS     = 4'd5;
  localparam logic [3:0] WORD_SEQ       = 4'd6;
  localparam logic [3:0] WORD_ACK       = 4'd7;
  localparam logic [3:0] WORD_OFF_WIN   = 4'd8;
  localparam logic [3:0] WORD_TCP_CSUM  = 4'd9;

  // Fixed header fields
  localparam logic [7:0]  IP_VER_IHL    = 8'h45;
  localparam logic [15:0] IP_TOTAL_LEN  = 16'd40;
  localparam logic [7:0]  IP_TTL        = 8'd64;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [15:0] TCP_SEG_LEN   = 16'd20;
  localparam logic [15:0] TCP_OFF_FLAGS = 16'h5002;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
  } item_t;

  typedef struct packed {
    logic [31:0] header_word;
    logic [3:0]  word_index;
    logic        last_word;
  } result_t;

  typedef struct packed {
    logic [15:0] ip_ident;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] window_size;
    logic [31:0] sequence_number;
  } cfg_t;

  typedef struct packed {
    logic [15:0] ip_csum;
    logic [15:0] tcp_csum;
  } csum_t;

endpackage

`default_nettype wire

[sv/tsg_csum.sv]
`timescale 1ns / 1ps
`default_nettype none

module tsg_csum
  import tsg_pkg::*;
(
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output csum_t      csum
);

  logic [19:0] ip_sum;
  logic [19:0] tcp_sum;

  // Fold carries back in twice, then complement
  function automatic logic [15:0] fold_sum(input logic [19:0] s);
    logic [16:0] s1;
    logic [15:0] s2;
    s1 = {1'b0, s[15:0]} + {13'b0, s[19:16]};
    s2 = s1[15:0] + {15'b0, s1[16]};
    return ~s2;
  endfunction

  always_comb begin
    ip_sum = 20'({IP_VER_IHL, 8'h00}) + 20'(IP_TOTAL_LEN) + 20'(cfg.ip_ident)
           + 20'({IP_TTL, PROTO_TCP})
           + 20'(item.src_addr[31:16]) + 20'(item.src_addr[15:0])
           + 20'(item.dst_addr[31:16]) + 20'(item.dst_addr[15:0]);
    // Pseudo-header plus TCP header
    tcp_sum = 20'(item.src_addr[31:16]) + 20'(item.src_addr[15:0])
            + 20'(item.dst_addr[31:16]) + 20'(item.dst_addr[15:0])
            + 20'(PROTO_TCP) + 20'(TCP_SEG_LEN)
            + 20'(cfg.source_port) + 20'(cfg.dest_port)
            + 20'(cfg.sequence_number[31:16]) + 20'(cfg.sequence_number[15:0])
            + 20'(TCP_OFF_FLAGS) + 20'(cfg.window_size);
    csum.ip_csum  = fold_sum(ip_sum);
    csum.tcp_csum = fold_sum(tcp_sum);
  end

endmodule

`default_nettype wire

[sv/tcp_syn_header_generator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                            Transfer
// -------   -------------------------------  ---------------------------------
// input     start, busy, item                edge with start high and busy low
// result    strobe, result                   every edge with strobe high
// config    cfg_we, cfg_index, cfg_data      every edge with cfg_we high
//
// One address pair yields ten result words on consecutive cycles, one word at a time
// on the single-word result port. When idle, an item passes through the holding
// register and then the emit register before its first word appears.
// A second item is held in the input register while the current header is sent,
// so headers follow each other with no gap; busy is high only when that holding
// register is full and cannot move on. Synchronous reset clears both valid flags
// and the configuration registers.

module tcp_syn_header_generator_unit
  import tsg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire item_t                 item,
  output logic                       strobe,
  output result_t                    result,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  logic  hold_valid;
  item_t hold_item;
  logic  emit_valid;
  item_t emit_item;
  csum_t emit_csum;
  logic [3:0] emit_idx;
  csum_t csum;
  logic  emit_load;
  logic  hold_load;
  logic  emit_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IP_IDENT: cfg.ip_ident        <= cfg_data[15:0];
        REG_SRC_PORT: cfg.source_port     <= cfg_data[15:0];
        REG_DST_PORT: cfg.dest_port       <= cfg_data[15:0];
        REG_WINDOW:   cfg.window_size     <= cfg_data[15:0];
        REG_SEQ_NUM:  cfg.sequence_number <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  tsg_csum u_csum (
    .item (hold_item),
    .cfg  (cfg),
    .csum (csum)
  );

  assign emit_done = emit_valid && (emit_idx == WORD_TCP_CSUM);
  assign emit_load = hold_valid && (!emit_valid || emit_done);
  assign busy      = hold_valid && !emit_load;
  assign hold_load = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (hold_load) begin
      hold_valid <= 1'b1;
    end else if (emit_load) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_load) begin
      hold_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_valid <= 1'b0;
      emit_idx   <= WORD_VER_LEN;
    end else if (emit_load) begin
      emit_valid <= 1'b1;
      emit_idx   <= WORD_VER_LEN;
    end else if (emit_done) begin
      emit_valid <= 1'b0;
      emit_idx   <= WORD_VER_LEN;
    end else if (emit_valid) begin
      emit_idx   <= emit_idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      emit_item <= hold_item;
      emit_csum <= csum;
    end
  end

  always_comb begin
    unique case (emit_idx)
      WORD_VER_LEN:  result.header_word = {IP_VER_IHL, 8'h00, IP_TOTAL_LEN};
      WORD_IDENT:    result.header_word = {cfg.ip_ident, 16'h0000};
      WORD_TTL_CSUM: result.header_word = {IP_TTL, PROTO_TCP, emit_csum.ip_csum};
      WORD_SRC_ADDR: result.header_word = emit_item.src_addr;
      WORD_DST_ADDR: result.header_word = emit_item.dst_addr;
      WORD_PORTS:    result.header_word = {cfg.source_port, cfg.dest_port};
      WORD_SEQ:      result.header_word = cfg.sequence_number;
      WORD_ACK:      result.header_word = 32'h0;
      WORD_OFF_WIN:  result.header_word = {TCP_OFF_FLAGS, cfg.window_size};
      WORD_TCP_CSUM: result.header_word = {emit_csum.tcp_csum, 16'h0000};
      default:       result.header_word = 32'h0;
    endcase
    result.word_index = emit_idx;
    result.last_word  = (emit_idx == WORD_TCP_CSUM);
  end

  assign strobe = emit_valid;

  a_words_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last_word) |=> (strobe && result.word_index == $past(emit_idx) + 4'd1))
    else $error("header words not sent back to back");

  a_header_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(strobe) |-> (result.word_index == WORD_VER_LEN))
    else $error("header did not start at word zero");

  a_busy_needs_holding: assert property (@(posedge clk) disable iff (rst)
    busy |-> (hold_valid && emit_valid && !result.last_word))
    else $error("busy raised without a stalled item");

  a_no_gap_with_pending: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last_word && hold_valid) |=> (strobe && result.word_index == WORD_VER_LEN))
    else $error("gap between headers with an item waiting");

endmodule

`default_nettype wire
